// ----- src/linear_probe_hash_map_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the linear-probe hash map
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define LPHM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked on every edge, reset included
`define LPHM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LPHM_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPHM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/lphm_pkg.sv -----
// ----------------------------------------------------------------------------
// Linear-probe hash map package
// Command, status and sequencer codes plus hashing constants.
// ----------------------------------------------------------------------------
package lphm_pkg;

	localparam int KEY_BITS   = 32;
	localparam int HASH_SHIFT = 32;
	localparam int HASH_BITS  = 16;
	localparam logic [63:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_HOME,
		ST_RD,
		ST_CHK,
		ST_REP_RD,
		ST_REP_CHK
	} state_t;

endpackage

// ----- src/linear_probe_hash_map_top.sv -----
// ----------------------------------------------------------------------------
// Linear-probe hash map
// Open-addressing map from stream key to connection index, probed one slot
// at a time by a small sequencer around a single slot store.
// ----------------------------------------------------------------------------
//  channel   strobe          payload
//  command   start / busy    command, stream_key, entry_value
//  result    done            status, found_value
//
//  Insert / lookup: busy while the key is hashed and each probed slot is read and checked; done follows.
//  Delete: as lookup, plus per cluster entry moved a read, a clear and a probe
//  to re-place it, plus a read of the slot ending the cluster.
//  Unused command code: result on the next cycle.
//  After reset the store is cleared slot by slot with busy high.
//  done lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_top_defines.svh"

module linear_probe_hash_map_top #(
	parameter int SLOTS      = 64,
	parameter int VALUE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            command,
	input  logic [31:0]           stream_key,
	input  logic [VALUE_BITS-1:0] entry_value,
	output logic                  busy,
	output logic                  done,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] found_value
);
	import lphm_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int DW = 1 + KEY_BITS + VALUE_BITS;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	state_t state_q, state_d;
	cmd_t   op_q;
	logic   reins_q;
	logic   done_q;
	logic [AW-1:0]         clr_q, idx_q, cnt_q, j_q, rep_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	status_t               status_q;
	logic [VALUE_BITS-1:0] found_q;

	logic [AW-1:0] home;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [DW-1:0] mem_wdata, mem_rdata;

	logic                  rd_valid, hit, last;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;

	logic                  fin;
	status_t               fin_status;
	logic [VALUE_BITS-1:0] fin_found;
	logic                  probe_step, rep_start, rep_next, rep_move;

	lphm_hash #(.SLOT_BITS(AW)) u_hash (
		.clk  (clk),
		.key  (key_q),
		.home (home)
	);

	lphm_store #(.ADDR_BITS(AW), .DATA_BITS(DW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_valid = mem_rdata[DW-1];
	assign rd_key   = mem_rdata[VALUE_BITS +: KEY_BITS];
	assign rd_val   = mem_rdata[VALUE_BITS-1:0];
	assign hit      = rd_valid && (rd_key == key_q);
	assign last     = (cnt_q == LAST_SLOT);

	// outputs and datapath controls
	always_comb begin
		busy       = (state_q != ST_IDLE);
		mem_we     = 1'b0;
		mem_waddr  = idx_q;
		mem_wdata  = '0;
		mem_raddr  = idx_q;
		fin        = 1'b0;
		fin_status = STATUS_OK;
		fin_found  = '0;
		probe_step = 1'b0;
		rep_start  = 1'b0;
		rep_next   = 1'b0;
		rep_move   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd_t'(command))
						CMD_INSERT, CMD_LOOKUP, CMD_DELETE: fin = 1'b0;
						default: fin = 1'b1;
					endcase
				end
			end
			ST_CHK: begin
				if (op_q == CMD_INSERT || reins_q) begin
					if (!rd_valid) begin
						mem_we    = 1'b1;
						mem_wdata = {1'b1, key_q, val_q};
						if (reins_q) begin
							rep_next = 1'b1;
						end else begin
							fin = 1'b1;
						end
					end else if (last) begin
						if (reins_q) begin
							rep_next = 1'b1;
						end else begin
							fin        = 1'b1;
							fin_status = STATUS_FULL;
						end
					end else begin
						probe_step = 1'b1;
					end
				end else begin
					if (!rd_valid) begin
						fin        = 1'b1;
						fin_status = STATUS_MISS;
					end else if (hit) begin
						if (op_q == CMD_DELETE) begin
							mem_we    = 1'b1;
							rep_start = 1'b1;
						end else begin
							fin       = 1'b1;
							fin_found = rd_val;
						end
					end else if (last) begin
						fin        = 1'b1;
						fin_status = STATUS_MISS;
					end else begin
						probe_step = 1'b1;
					end
				end
			end
			ST_REP_RD: begin
				mem_raddr = j_q;
				if (rep_q == LAST_SLOT) begin
					fin = 1'b1;
				end
			end
			ST_REP_CHK: begin
				if (!rd_valid) begin
					fin = 1'b1;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = j_q;
					rep_move  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && !fin) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: state_d = ST_HOME;
			ST_HOME: state_d = ST_RD;
			ST_RD:   state_d = ST_CHK;
			ST_CHK: begin
				if (fin) begin
					state_d = ST_IDLE;
				end else if (probe_step) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_REP_RD;
				end
			end
			ST_REP_RD:  state_d = fin ? ST_IDLE : ST_REP_CHK;
			ST_REP_CHK: state_d = fin ? ST_IDLE : ST_HASH;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			reins_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_IDLE && start) begin
				reins_q <= 1'b0;
			end else if (rep_move) begin
				reins_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start && !fin) begin
			op_q  <= cmd_t'(command);
			key_q <= stream_key;
			val_q <= entry_value;
		end
		if (rep_move) begin
			key_q <= rd_key;
			val_q <= rd_val;
		end
		if (state_q == ST_HOME) begin
			idx_q <= home;
			cnt_q <= '0;
		end else if (probe_step) begin
			idx_q <= idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (rep_start) begin
			j_q   <= idx_q + 1'b1;
			rep_q <= '0;
		end else if (rep_next) begin
			j_q   <= j_q + 1'b1;
			rep_q <= rep_q + 1'b1;
		end
		if (fin) begin
			status_q <= fin_status;
			found_q  <= fin_found;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;

	`LPHM_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result while busy")
	`LPHM_ASSERT(a_accept_moves, clk, arst_n, (start && !busy) |=> (busy || done), "item dropped")
	`LPHM_ASSERT(a_miss_zero, clk, arst_n, (done && status != STATUS_OK) |-> (found_value == '0), "value on miss")
	`LPHM_ASSERT(a_home_after_hash, clk, arst_n, (state_q == ST_HOME) |-> ($past(state_q) == ST_HASH), "home not hashed")
	`LPHM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !done, "result in reset")

endmodule

// ----- src/lphm_hash.sv -----
// ----------------------------------------------------------------------------
// Home slot hash
// Golden-ratio multiplicative hash, one register stage after the multipliers.
// ----------------------------------------------------------------------------
module lphm_hash #(
	parameter int SLOT_BITS = 6
) (
	input  logic                           clk,
	input  logic [lphm_pkg::KEY_BITS-1:0]  key,
	output logic [SLOT_BITS-1:0]           home
);
	import lphm_pkg::*;

	logic [63:0]          lo_full;
	logic [31:0]          mid_full;
	logic [HASH_BITS-1:0] lo_s1;
	logic [HASH_BITS-1:0] mid_s1;
	logic [HASH_BITS-1:0] sum;

	// bits 47..32 of key * C: upper part of key * C[31:0] plus key * C[47:32]
	assign lo_full  = {32'b0, key} * {32'b0, GOLDEN_MUL[31:0]};
	assign mid_full = {16'b0, key[HASH_BITS-1:0]} * {16'b0, GOLDEN_MUL[HASH_SHIFT +: HASH_BITS]};

	always_ff @(posedge clk) begin
		lo_s1  <= lo_full[HASH_SHIFT +: HASH_BITS];
		mid_s1 <= mid_full[HASH_BITS-1:0];
	end

	assign sum  = lo_s1 + mid_s1;
	assign home = sum[SLOT_BITS-1:0];

endmodule

// ----- src/lphm_store.sv -----
// ----------------------------------------------------------------------------
// Slot store
// One write port, one registered read port; word is valid, key and value.
// ----------------------------------------------------------------------------
module lphm_store #(
	parameter int ADDR_BITS = 6,
	parameter int DATA_BITS = 43
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- test/linear_probe_hash_map_top_tb.sv -----
// ----------------------------------------------------------------------------
// Linear-probe hash map testbench
// Drives insert, lookup, delete and unused commands through the start/busy
// port and checks every done item against a slot-level copy of the map.
// Directed items cover empty-table misses, duplicate keys, wrap-around
// clusters and delete repair. Random items then fill the table to full and
// drain it again, several times over.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lphm_pkg::*;

	localparam int SLOTS         = 64;
	localparam int VALUE_BITS    = 10;
	localparam int SLOT_BITS     = $clog2(SLOTS);
	localparam int RANDOM_ITEMS  = 1100;
	localparam int STALL_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		status_t                 st;
		logic [VALUE_BITS-1:0]   value;
	} map_result_t;

	class slot_table_model;
		bit                    used[SLOTS];
		logic [31:0]           key_of[SLOTS];
		logic [VALUE_BITS-1:0] value_of[SLOTS];
		int                    occupancy;
		map_result_t           pending[$];

		static function logic [SLOT_BITS-1:0] home_of(logic [31:0] key);
			logic [63:0] prod;
			prod = {32'd0, key} * GOLDEN_MUL;
			return prod[HASH_SHIFT +: SLOT_BITS];
		endfunction

		function bit first_free(logic [31:0] key, output int idx);
			int s;
			s = home_of(key);
			for (int n = 0; n < SLOTS; n++) begin
				if (!used[s]) begin
					idx = s;
					return 1'b1;
				end
				s = (s + 1) % SLOTS;
			end
			return 1'b0;
		endfunction

		function bit locate(logic [31:0] key, output int idx);
			int s;
			s = home_of(key);
			for (int n = 0; n < SLOTS; n++) begin
				if (!used[s])
					return 1'b0;
				if (key_of[s] == key) begin
					idx = s;
					return 1'b1;
				end
				s = (s + 1) % SLOTS;
			end
			return 1'b0;
		endfunction

		function void apply_command(logic [1:0] cmd, logic [31:0] key,
				logic [VALUE_BITS-1:0] value);
			map_result_t           res;
			int                    s, j, t;
			logic [31:0]           k;
			logic [VALUE_BITS-1:0] v;
			res.st    = STATUS_OK;
			res.value = '0;
			case (cmd)
				CMD_INSERT: begin
					if (first_free(key, s)) begin
						used[s]     = 1'b1;
						key_of[s]   = key;
						value_of[s] = value;
						occupancy++;
					end else
						res.st = STATUS_FULL;
				end
				CMD_LOOKUP: begin
					if (locate(key, s))
						res.value = value_of[s];
					else
						res.st = STATUS_MISS;
				end
				CMD_DELETE: begin
					if (locate(key, s)) begin
						used[s] = 1'b0;
						occupancy--;
						j = (s + 1) % SLOTS;
						// re-place the rest of the cluster
						for (int n = 0; n + 1 < SLOTS && used[j]; n++) begin
							k       = key_of[j];
							v       = value_of[j];
							used[j] = 1'b0;
							if (first_free(k, t)) begin
								used[t]     = 1'b1;
								key_of[t]   = k;
								value_of[t] = v;
							end
							j = (j + 1) % SLOTS;
						end
					end else
						res.st = STATUS_MISS;
				end
				default: ;
			endcase
			pending.push_back(res);
		endfunction

		function bit match_result(logic [1:0] st, logic [VALUE_BITS-1:0] value,
				output string why);
			map_result_t want;
			if (pending.size() == 0) begin
				why = $sformatf("unexpected item: status %0d found_value %0d", st, value);
				return 1'b0;
			end
			want = pending.pop_front();
			why  = "";
			if (st !== want.st)
				why = $sformatf("status %0d, expected %0d; ", st, want.st);
			if (value !== want.value)
				why = {why, $sformatf("found_value %0d, expected %0d", value, want.value)};
			return why == "";
		endfunction

		function bit pick_stored(inout logic [31:0] key);
			int s;
			if (occupancy == 0)
				return 1'b0;
			do
				s = $urandom_range(SLOTS - 1);
			while (!used[s]);
			key = key_of[s];
			return 1'b1;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic [1:0]            command;
	logic [31:0]           stream_key;
	logic [VALUE_BITS-1:0] entry_value;
	logic                  busy;
	logic                  done;
	logic [1:0]            status;
	logic [VALUE_BITS-1:0] found_value;

	slot_table_model slot_map = new();
	int              errors;
	int              gap_pct;
	int              quiet_cycles;
	logic [31:0]     hot_keys[16];
	logic [31:0]     wrap_keys[3];

	linear_probe_hash_map_top #(
		.SLOTS(SLOTS),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.stream_key(stream_key),
		.entry_value(entry_value),
		.busy(busy),
		.done(done),
		.status(status),
		.found_value(found_value)
	);

	always #2 clk = ~clk;

	task automatic report(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	function automatic logic [31:0] key_homed(int lo, int hi);
		logic [31:0] key;
		do
			key = $urandom;
		while (slot_table_model::home_of(key) < lo || slot_table_model::home_of(key) > hi);
		return key;
	endfunction

	task automatic issue(logic [1:0] cmd, logic [31:0] key, logic [VALUE_BITS-1:0] value);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		command     <= cmd;
		stream_key  <= key;
		entry_value <= value;
		do
			@(posedge clk);
		while (busy);
		slot_map.apply_command(cmd, key, value);
	endtask

	always @(posedge clk) begin
		string why;
		if (arst_n && done) begin
			if (!slot_map.match_result(status, found_value, why))
				report(why);
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		bit                    filling;
		int                    full_tries;
		int                    low_mark;
		int                    roll;
		logic [1:0]            cmd;
		logic [31:0]           key;
		logic [VALUE_BITS-1:0] value;

		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = CMD_INSERT;
		stream_key   = '0;
		entry_value  = '0;
		errors       = 0;
		quiet_cycles = 0;
		gap_pct      = 33;

		foreach (hot_keys[i])
			hot_keys[i] = key_homed(SLOTS - 4, SLOTS - 1);
		foreach (wrap_keys[i])
			wrap_keys[i] = key_homed(SLOTS - 1, SLOTS - 1);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed
		issue(CMD_LOOKUP, 32'h0, '0);
		issue(CMD_DELETE, 32'h0, '0);
		issue(CMD_INSERT, 32'h0, '0);
		issue(CMD_INSERT, 32'hffff_ffff, '1);
		issue(CMD_LOOKUP, 32'h0, '1);
		issue(CMD_LOOKUP, 32'hffff_ffff, '0);
		issue(CMD_INSERT, 32'hffff_ffff, 10'h155);
		issue(CMD_LOOKUP, 32'hffff_ffff, '0);
		issue(CMD_UNUSED, 32'hffff_ffff, '1);
		issue(CMD_DELETE, 32'hffff_ffff, '0);
		issue(CMD_LOOKUP, 32'hffff_ffff, '0);
		issue(CMD_DELETE, 32'h8000_0000, '0);
		issue(CMD_INSERT, wrap_keys[0], 10'h2aa);
		issue(CMD_INSERT, wrap_keys[1], 10'h0f0);
		issue(CMD_INSERT, wrap_keys[2], 10'h30f);
		issue(CMD_LOOKUP, wrap_keys[2], '0);
		issue(CMD_DELETE, wrap_keys[0], '0);
		issue(CMD_LOOKUP, wrap_keys[0], '0);
		issue(CMD_LOOKUP, wrap_keys[1], '0);
		issue(CMD_LOOKUP, wrap_keys[2], '0);
		issue(CMD_LOOKUP, 32'h0, '0);
		issue(CMD_DELETE, 32'h0, '0);
		issue(CMD_LOOKUP, wrap_keys[2], '0);

		// random fill / drain episodes
		filling    = 1'b1;
		full_tries = 0;
		low_mark   = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < RANDOM_ITEMS / 3)
				gap_pct = 33;
			else if (i < 2 * RANDOM_ITEMS / 3)
				gap_pct = 57;
			else
				gap_pct = 0;

			roll = $urandom_range(99);
			if (roll < 3)
				cmd = CMD_UNUSED;
			else if (filling)
				cmd = roll < 58 ? CMD_INSERT : roll < 78 ? CMD_LOOKUP : CMD_DELETE;
			else
				cmd = roll < 23 ? CMD_INSERT : roll < 48 ? CMD_LOOKUP : CMD_DELETE;

			roll = $urandom_range(9);
			key  = $urandom;
			if (cmd == CMD_INSERT) begin
				if (roll < 2)
					key = hot_keys[$urandom_range(15)];
				else if (roll == 2)
					void'(slot_map.pick_stored(key));
			end else begin
				if (roll < 8)
					void'(slot_map.pick_stored(key));
				else if (roll == 8)
					key = hot_keys[$urandom_range(15)];
			end
			value = VALUE_BITS'($urandom);

			issue(cmd, key, value);

			if (filling && slot_map.occupancy == SLOTS && cmd == CMD_INSERT) begin
				full_tries++;
				if (full_tries >= 3)
					filling = 1'b0;
			end else if (!filling && slot_map.occupancy <= low_mark) begin
				filling    = 1'b1;
				full_tries = 0;
				low_mark   = $urandom_range(16);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (slot_map.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/lphm_pkg.sv
src/lphm_hash.sv
src/lphm_store.sv
src/linear_probe_hash_map_top.sv
test/linear_probe_hash_map_top_tb.sv
